[hw/rtl/go_back_n_sender_window_unit_macros.svh]
// assertion macros used by the checker file
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define GBN_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define GBN_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gbn_pkg.sv]
package gbn_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SEQ_W   = 8;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 7;
    localparam int TMO_W   = 20;
    localparam int QUOTA_W = 32;
    localparam int CFG_W   = 32;
    localparam int REG_IDX_W = 1;

    // sequence space and window, bounded by the 8-bit sequence fields
    localparam int unsigned SEQ_SPACE  = 256;
    localparam int unsigned WINDOW     = 64;
    localparam int unsigned MAX_BURST  = 64;
    localparam int          MOD_W      = SEQ_W + 1;
    localparam int unsigned EFF_WIN_A  = (WINDOW < SEQ_SPACE - 1) ? WINDOW : SEQ_SPACE - 1;
    localparam int unsigned EFF_WINDOW = (EFF_WIN_A < MAX_BURST) ? EFF_WIN_A : MAX_BURST;

    localparam logic [MOD_W-1:0]   SEQ_MOD   = MOD_W'(SEQ_SPACE);
    localparam logic [SEQ_W-1:0]   EFF_WIN   = SEQ_W'(EFF_WINDOW);

    // register reset values
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = TMO_W'(20000);
    localparam logic [QUOTA_W-1:0] QUOTA_RESET   = QUOTA_W'(1000000);
    localparam logic [TMO_W-1:0]   ELAPSED_MAX   = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NEW     = 3'd0,
        EV_RESENT  = 3'd1,
        EV_ACK     = 3'd2,
        EV_IGNORED = 3'd3,
        EV_NONE    = 3'd4
    } event_kind_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TIMEOUT = 1'b0,
        REG_QUOTA   = 1'b1
    } reg_index_t;

    // (a + 1) mod SEQ_SPACE
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
        logic [MOD_W-1:0] s;
        s = {1'b0, a} + MOD_W'(1);
        if (s >= SEQ_MOD)
            s = s - SEQ_MOD;
        return s[SEQ_W-1:0];
    endfunction

    // (a + n) mod SEQ_SPACE, n below SEQ_SPACE
    function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                 input logic [CNT_W-1:0] n);
        logic [MOD_W-1:0] s;
        s = {1'b0, a} + MOD_W'(n);
        if (s >= SEQ_MOD)
            s = s - SEQ_MOD;
        return s[SEQ_W-1:0];
    endfunction

    // (a - b) mod SEQ_SPACE
    function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [MOD_W-1:0] d;
        if (a >= b)
            d = {1'b0, a} - {1'b0, b};
        else
            d = ({1'b0, a} + SEQ_MOD) - {1'b0, b};
        return d[SEQ_W-1:0];
    endfunction

endpackage

[hw/rtl/gbn_if.sv]
interface gbn_cmd_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SEQ_W-1:0] ack_number;
    logic             ack_good;

    modport source (output valid, command, ack_number, ack_good, input ready);
    modport sink   (input valid, command, ack_number, ack_good, output ready);
endinterface

interface gbn_evt_if import gbn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [SEQ_W-1:0]  frame_number;
    logic [CNT_W-1:0]  acked_count;
    logic              quota_done;
    logic              window_empty;
    logic              last;

    modport source (output valid, event_kind, frame_number, acked_count, quota_done,
                    window_empty, last, input ready);
    modport sink   (input valid, event_kind, frame_number, acked_count, quota_done,
                    window_empty, last, output ready);
endinterface

[hw/rtl/go_back_n_sender_window_unit.sv]
// channel  dir  payload                                                  word
// cmd      in   command, ack_number, ack_good                            one command
// evt      out  event_kind, frame_number, acked_count, quota_done,       one result
//               window_empty, last
// cfg      in   cfg_we, cfg_index, cfg_data (no handshake)               one register
//
// a command goes through accept (idle), evaluate and one emit step per result:
// one result for ack, idle and unexpired tick, n for a burst of n frames (n up to 64)
// the evaluate cycle holds the one shared 32-bit subtract/compare (quota against issued)
// cmd.ready is high only in idle; a held result in the evt register stalls the burst
// rst_n is asynchronous, active low: window, counters and timer cleared, registers
// back to timeout 20000 ticks and quota 1000000 frames
module go_back_n_sender_window_unit
    import gbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    gbn_cmd_if.sink              cmd,
    gbn_evt_if.source            evt,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // sequencer and window state
    state_t              state_reg,   state_next;
    logic [TMO_W-1:0]    timeout_reg, timeout_next;
    logic [QUOTA_W-1:0]  quota_reg,   quota_next;
    logic [SEQ_W-1:0]    base_reg,    base_next;
    logic [SEQ_W-1:0]    next_num_reg, next_num_next;
    logic [QUOTA_W-1:0]  issued_reg,  issued_next;
    logic [QUOTA_W-1:0]  acked_reg,   acked_next;
    logic                running_reg, running_next;
    logic [TMO_W-1:0]    elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]    remain_reg,  remain_next;
    logic                evt_valid_reg, evt_valid_next;

    // latched command word
    cmd_code_t           cmd_reg,  cmd_next;
    logic [SEQ_W-1:0]    ack_reg,  ack_next;
    logic                good_reg, good_next;

    // burst descriptor set up in the evaluate cycle
    event_kind_t         kind_reg,  kind_next;
    logic [SEQ_W-1:0]    frame_reg, frame_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                qdone_reg, qdone_next;
    logic                empty_reg, empty_next;

    // result register
    event_kind_t         out_kind_reg,  out_kind_next;
    logic [SEQ_W-1:0]    out_frame_reg, out_frame_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic                out_qdone_reg, out_qdone_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_last_reg,  out_last_next;

    // evaluate-cycle datapath
    logic [SEQ_W-1:0]    outstanding;
    logic [QUOTA_W:0]    quota_diff;      // shared subtractor, msb is the borrow
    logic [QUOTA_W-1:0]  quota_left;
    logic                quota_open;
    logic [SEQ_W-1:0]    avail;
    logic [CNT_W-1:0]    fill_n;
    logic                fill_qdone;
    logic [SEQ_W-1:0]    ack_offset;
    logic                ack_ok;
    logic [SEQ_W-1:0]    new_base;
    logic [TMO_W-1:0]    el_inc;
    logic [TMO_W-1:0]    limit;
    logic                load_word;

    always_comb
    begin
        outstanding = seq_sub(next_num_reg, base_reg);

        // quota - issued; no borrow and nonzero means frames are still owed
        quota_diff  = {1'b0, quota_reg} - {1'b0, issued_reg};
        quota_left  = quota_diff[QUOTA_W-1:0];
        quota_open  = !quota_diff[QUOTA_W] && (quota_left != '0);

        // free window slots, then clip by what the quota still allows
        avail = EFF_WIN - outstanding;
        if (!quota_open)
            fill_n = '0;
        else if (quota_left < QUOTA_W'(avail))
            fill_n = quota_left[CNT_W-1:0];
        else
            fill_n = avail[CNT_W-1:0];
        fill_qdone = !quota_open || (quota_left <= QUOTA_W'(avail));

        // cumulative ack must land inside the outstanding frames
        ack_offset = seq_sub(ack_reg, base_reg);
        ack_ok     = good_reg && ({1'b0, ack_reg} < SEQ_MOD) && (ack_offset < outstanding);
        new_base   = seq_inc(ack_reg);

        // saturating timer, zero timeout counts as one
        el_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + TMO_W'(1);
        limit  = (timeout_reg == '0) ? TMO_W'(1) : timeout_reg;
    end

    assign load_word = (state_reg == S_EMIT) && (!evt_valid_reg || evt.ready);

    always_comb
    begin
        state_next     = state_reg;
        timeout_next   = timeout_reg;
        quota_next     = quota_reg;
        base_next      = base_reg;
        next_num_next  = next_num_reg;
        issued_next    = issued_reg;
        acked_next     = acked_reg;
        running_next   = running_reg;
        elapsed_next   = elapsed_reg;
        remain_next    = remain_reg;
        cmd_next       = cmd_reg;
        ack_next       = ack_reg;
        good_next      = good_reg;
        kind_next      = kind_reg;
        frame_next     = frame_reg;
        count_next     = count_reg;
        qdone_next     = qdone_reg;
        empty_next     = empty_reg;
        out_kind_next  = out_kind_reg;
        out_frame_next = out_frame_reg;
        out_count_next = out_count_reg;
        out_qdone_next = out_qdone_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        // result register drains when taken
        if (load_word)
            evt_valid_next = 1'b1;
        else if (evt.ready)
            evt_valid_next = 1'b0;
        else
            evt_valid_next = evt_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd_code_t'(cmd.command);
                    ack_next   = cmd.ack_number;
                    good_next  = cmd.ack_good;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                // defaults: a single result, state after the step
                kind_next   = EV_NONE;
                remain_next = CNT_W'(1);
                count_next  = '0;
                frame_next  = '0;
                qdone_next  = !quota_open;
                empty_next  = (outstanding == '0);
                state_next  = S_EMIT;

                unique case (cmd_reg)
                    CMD_FILL:
                    begin
                        qdone_next = fill_qdone;
                        if (fill_n != '0)
                        begin
                            kind_next     = EV_NEW;
                            remain_next   = fill_n;
                            frame_next    = next_num_reg;
                            next_num_next = seq_add(next_num_reg, fill_n);
                            issued_next   = issued_reg + QUOTA_W'(fill_n);
                            empty_next    = 1'b0;
                            // first frame into an empty window starts the timer
                            if (base_reg == next_num_reg)
                            begin
                                running_next = 1'b1;
                                elapsed_next = '0;
                            end
                        end
                    end

                    CMD_ACK:
                    begin
                        if (ack_ok)
                        begin
                            kind_next  = EV_ACK;
                            count_next = ack_offset[CNT_W-1:0] + CNT_W'(1);
                            acked_next = acked_reg + QUOTA_W'(ack_offset) + QUOTA_W'(1);
                            base_next  = new_base;
                            // timer stops once everything is acked, else restarts
                            running_next = (new_base != next_num_reg);
                            elapsed_next = '0;
                            empty_next   = (new_base == next_num_reg);
                        end
                        else
                        begin
                            kind_next = EV_IGNORED;
                        end
                    end

                    CMD_TICK:
                    begin
                        if (running_reg)
                        begin
                            elapsed_next = el_inc;
                            if (el_inc >= limit)
                            begin
                                // timeout: resend the whole window from base
                                elapsed_next = '0;
                                if (outstanding == '0)
                                begin
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    running_next = 1'b1;
                                    kind_next    = EV_RESENT;
                                    remain_next  = outstanding[CNT_W-1:0];
                                    frame_next   = base_reg;
                                end
                            end
                        end
                    end

                    CMD_NONE:
                    begin
                        kind_next = EV_NONE;
                    end

                    default:
                    begin
                        kind_next = EV_NONE;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (load_word)
                begin
                    out_kind_next  = kind_reg;
                    out_frame_next = (kind_reg == EV_NEW || kind_reg == EV_RESENT)
                                     ? frame_reg : '0;
                    out_count_next = count_reg;
                    out_qdone_next = qdone_reg;
                    out_empty_next = empty_reg;
                    out_last_next  = (remain_reg == CNT_W'(1));
                    frame_next     = seq_inc(frame_reg);
                    remain_next    = remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes, to be issued only while idle; the block does not enforce this
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TIMEOUT: timeout_next = cfg_data[TMO_W-1:0];
                REG_QUOTA:   quota_next   = cfg_data[QUOTA_W-1:0];
                default:     timeout_next = timeout_reg;
            endcase
        end
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            timeout_reg   <= TIMEOUT_RESET;
            quota_reg     <= QUOTA_RESET;
            base_reg      <= '0;
            next_num_reg  <= '0;
            issued_reg    <= '0;
            acked_reg     <= '0;
            running_reg   <= 1'b0;
            elapsed_reg   <= '0;
            remain_reg    <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timeout_reg   <= timeout_next;
            quota_reg     <= quota_next;
            base_reg      <= base_next;
            next_num_reg  <= next_num_next;
            issued_reg    <= issued_next;
            acked_reg     <= acked_next;
            running_reg   <= running_next;
            elapsed_reg   <= elapsed_next;
            remain_reg    <= remain_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ack_reg       <= ack_next;
        good_reg      <= good_next;
        kind_reg      <= kind_next;
        frame_reg     <= frame_next;
        count_reg     <= count_next;
        qdone_reg     <= qdone_next;
        empty_reg     <= empty_next;
        out_kind_reg  <= out_kind_next;
        out_frame_reg <= out_frame_next;
        out_count_reg <= out_count_next;
        out_qdone_reg <= out_qdone_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign cmd.ready        = (state_reg == S_IDLE);
    assign evt.valid        = evt_valid_reg;
    assign evt.event_kind   = out_kind_reg;
    assign evt.frame_number = out_frame_reg;
    assign evt.acked_count  = out_count_reg;
    assign evt.quota_done   = out_qdone_reg;
    assign evt.window_empty = out_empty_reg;
    assign evt.last         = out_last_reg;

endmodule

[hw/rtl/gbn_checker.sv]
`include "go_back_n_sender_window_unit_macros.svh"

module gbn_checker
    import gbn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              evt_valid,
    input logic              evt_ready,
    input logic [KIND_W-1:0] evt_kind,
    input logic [SEQ_W-1:0]  evt_frame,
    input logic [CNT_W-1:0]  evt_count,
    input logic              evt_last
);

    // busy right after taking a command
    `GBN_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")

    // frame number only on new and resent frames
    `GBN_ASSERT_NOW(a_frame_zero, clk, rst_n, evt_valid && evt_kind != EV_NEW && evt_kind != EV_RESENT, evt_frame == '0, "frame number on non-frame word")

    // acked count only on an accepted ack
    `GBN_ASSERT_NOW(a_count_zero, clk, rst_n, evt_valid && evt_kind != EV_ACK, evt_count == '0, "acked count on non-ack word")

    // single-result kinds close their command
    `GBN_ASSERT_NOW(a_single_last, clk, rst_n, evt_valid && (evt_kind == EV_ACK || evt_kind == EV_IGNORED || evt_kind == EV_NONE), evt_last, "single result without last")

    // stalled word holds
    `GBN_ASSERT_NEXT(a_stall_hold, clk, rst_n, evt_valid && !evt_ready, evt_valid && $stable(evt_kind) && $stable(evt_frame) && $stable(evt_last), "stalled word changed")

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .evt_kind  (evt.event_kind),
    .evt_frame (evt.frame_number),
    .evt_count (evt.acked_count),
    .evt_last  (evt.last)
);
